### rtl/mwlsm_pkg.sv
// shared types and constants for the multi-wall limit switch mover
// no dependencies
package mwlsm_pkg;

  localparam int WALL_SLOTS      = 5;
  localparam int WALL_COUNT_DEF  = 5;
  localparam int DUTY_W          = 8;
  localparam int TICK_W          = 16;
  localparam int COUNT_W         = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [DUTY_W-1:0] DUTY_RESET    = 8'd255;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd2500;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_DUTY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  typedef struct packed {
    logic       check;
    logic       start;
    logic       clear;
    logic [1:0] dir;
  } wall_ctrl_t;

endpackage

### rtl/mwlsm_wall.sv
// one wall: switch latch, down-hit counter and done flag
// depends on mwlsm_pkg
module mwlsm_wall import mwlsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  wall_ctrl_t         ctrl,
  input  logic               up_sw,
  input  logic               down_sw,
  output logic               done_next,
  output logic [COUNT_W-1:0] count
);

  logic [1:0]         latch;
  logic [1:0]         latch_next;
  logic [COUNT_W-1:0] count_next;
  logic               done;
  logic [1:0]         hit;

  always_comb begin
    latch_next = latch;
    count_next = count;
    done_next  = done;
    hit        = DIR_NONE;
    if (ctrl.start) begin
      done_next = 1'b0;
    end
    if (ctrl.clear) begin
      count_next = '0;
    end
    if (ctrl.check && !done) begin
      if (down_sw && latch != DIR_DOWN) begin
        latch_next = DIR_DOWN;
        count_next = count + COUNT_W'(1);
        hit        = DIR_DOWN;
      end else if (up_sw && latch != DIR_UP) begin
        latch_next = DIR_UP;
        hit        = DIR_UP;
      end
      if (hit != DIR_NONE && hit == ctrl.dir) begin
        done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= DIR_NONE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      latch <= latch_next;
      count <= count_next;
      done  <= done_next;
    end
  end

endmodule

### rtl/multi_wall_limit_switch_mover_core.sv
// result: valid in the cycle after its request is accepted
// throughput: one request per cycle; in_ready follows the result register
// (free or being taken), so requests flow back to back under no stall
// reset: sync active high; drives off, latches, counts and flags cleared,
// duties 255, timeout 2500 ticks
module multi_wall_limit_switch_mover_core import mwlsm_pkg::*; #(
  parameter int WALL_COUNT = WALL_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [1:0]            run_direction,
  input  logic [4:0]            up_switches,
  input  logic [4:0]            down_switches,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4:0]            drive_down_mask,
  output logic [4:0]            drive_up_mask,
  output logic [DUTY_W-1:0]     down_level,
  output logic [DUTY_W-1:0]     up_level,
  output logic                  busy_res,
  output logic                  timed_out,
  output logic [COUNT_W-1:0]    count_wall0,
  output logic [COUNT_W-1:0]    count_wall1,
  output logic [COUNT_W-1:0]    count_wall2,
  output logic [COUNT_W-1:0]    count_wall3,
  output logic [COUNT_W-1:0]    count_wall4
);

  logic [DUTY_W-1:0] up_duty;
  logic [DUTY_W-1:0] down_duty;
  logic [TICK_W-1:0] timeout_ticks;

  logic              running;
  logic              running_next;
  logic [1:0]        active_dir;
  logic [1:0]        active_dir_next;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] elapsed_next;
  logic              timeout_flag;
  logic              timeout_flag_next;

  logic              accept;
  wall_ctrl_t        ctrl;
  logic [WALL_SLOTS-1:0] done_vec;
  logic [COUNT_W-1:0]    counts [WALL_SLOTS];
  logic [WALL_SLOTS-1:0] live;
  logic [4:0]            dmask;
  logic [4:0]            umask;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      up_duty       <= DUTY_RESET;
      down_duty     <= DUTY_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_UP_DUTY:   up_duty       <= cfg_data[DUTY_W-1:0];
        CFG_DOWN_DUTY: down_duty     <= cfg_data[DUTY_W-1:0];
        CFG_TIMEOUT:   timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-wall control
  always_comb begin
    ctrl.check = accept && kind == KIND_TICK && running && (elapsed < timeout_ticks);
    ctrl.start = accept && kind == KIND_START &&
                 (run_direction == DIR_DOWN || run_direction == DIR_UP);
    ctrl.clear = accept && kind == KIND_CLEAR;
    ctrl.dir   = active_dir;
  end

  for (genvar g = 0; g < WALL_SLOTS; g++) begin : g_wall
    if (g < WALL_COUNT) begin : g_live
      mwlsm_wall u_wall (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .up_sw     (up_switches[g]),
        .down_sw   (down_switches[g]),
        .done_next (done_vec[g]),
        .count     (counts[g])
      );
    end else begin : g_absent
      assign done_vec[g] = 1'b1;
      assign counts[g]   = '0;
    end
  end

  // run control
  always_comb begin
    running_next      = running;
    active_dir_next   = active_dir;
    elapsed_next      = elapsed;
    timeout_flag_next = timeout_flag;
    if (accept) begin
      case (kind)
        KIND_TICK: begin
          if (running) begin
            if (ctrl.check) begin
              elapsed_next = elapsed + TICK_W'(1);
            end
            if (elapsed_next >= timeout_ticks) begin
              running_next      = 1'b0;
              timeout_flag_next = !(&done_vec);
            end
          end
        end
        KIND_START: begin
          if (ctrl.start) begin
            running_next      = 1'b1;
            active_dir_next   = run_direction;
            elapsed_next      = '0;
            timeout_flag_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      active_dir   <= DIR_NONE;
      elapsed      <= '0;
      timeout_flag <= 1'b0;
    end else begin
      running      <= running_next;
      active_dir   <= active_dir_next;
      elapsed      <= elapsed_next;
      timeout_flag <= timeout_flag_next;
    end
  end

  // result formation
  always_comb begin
    live  = ~done_vec;
    dmask = '0;
    umask = '0;
    if (running_next) begin
      if (active_dir_next == DIR_DOWN) begin
        dmask = live;
      end else if (active_dir_next == DIR_UP) begin
        umask = live;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_down_mask <= '0;
      drive_up_mask   <= '0;
      down_level      <= '0;
      up_level        <= '0;
      busy_res        <= 1'b0;
      timed_out       <= 1'b0;
    end else if (accept) begin
      drive_down_mask <= dmask;
      drive_up_mask   <= umask;
      down_level      <= (dmask != '0) ? down_duty : '0;
      up_level        <= (umask != '0) ? up_duty : '0;
      busy_res        <= running_next;
      timed_out       <= timeout_flag_next;
    end
  end

  // counters are already registered inside the walls and change only on accept
  assign count_wall0 = counts[0];
  assign count_wall1 = counts[1];
  assign count_wall2 = counts[2];
  assign count_wall3 = counts[3];
  assign count_wall4 = counts[4];

endmodule

### tb/sv/tb_multi_wall_limit_switch_mover_core.sv
// testbench for multi_wall_limit_switch_mover_core: directed and random runs of the
// wall mover, checked result by result against an in-bench model of the walls
// depends on mwlsm_pkg and the core rtl
module tb_multi_wall_limit_switch_mover_core;
  import mwlsm_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] DIR_BAD    = 2'd3;
  localparam logic [4:0] ALL_WALLS  = 5'h1f;
  localparam int         HOLD_LEN   = 80;

  typedef struct packed {
    logic [4:0]              down_mask;
    logic [4:0]              up_mask;
    logic [DUTY_W-1:0]       down_lvl;
    logic [DUTY_W-1:0]       up_lvl;
    logic                    busy;
    logic                    tout;
    logic [4:0][COUNT_W-1:0] counts;
  } motion_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            kind = KIND_TICK;
  logic [1:0]            run_direction = DIR_NONE;
  logic [4:0]            up_switches = '0;
  logic [4:0]            down_switches = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [4:0]            drive_down_mask;
  logic [4:0]            drive_up_mask;
  logic [DUTY_W-1:0]     down_level;
  logic [DUTY_W-1:0]     up_level;
  logic                  busy_res;
  logic                  timed_out;
  logic [COUNT_W-1:0]    count_wall0;
  logic [COUNT_W-1:0]    count_wall1;
  logic [COUNT_W-1:0]    count_wall2;
  logic [COUNT_W-1:0]    count_wall3;
  logic [COUNT_W-1:0]    count_wall4;

  multi_wall_limit_switch_mover_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .run_direction(run_direction),
    .up_switches(up_switches), .down_switches(down_switches),
    .out_valid(out_valid), .out_ready(out_ready),
    .drive_down_mask(drive_down_mask), .drive_up_mask(drive_up_mask),
    .down_level(down_level), .up_level(up_level),
    .busy_res(busy_res), .timed_out(timed_out),
    .count_wall0(count_wall0), .count_wall1(count_wall1), .count_wall2(count_wall2),
    .count_wall3(count_wall3), .count_wall4(count_wall4)
  );

  // model of the walls
  logic [1:0]         latch_m [5];
  logic [COUNT_W-1:0] wall_cnt [5];
  logic [4:0]         done_m = '0;
  logic               run_m = 1'b0;
  logic [1:0]         dir_m = DIR_NONE;
  logic [TICK_W-1:0]  elapsed_m = '0;
  logic               tflag_m = 1'b0;
  logic [DUTY_W-1:0]  up_duty_m = DUTY_RESET;
  logic [DUTY_W-1:0]  down_duty_m = DUTY_RESET;
  logic [TICK_W-1:0]  timeout_m = TIMEOUT_RESET;

  motion_t pending_motion [$];
  int      errors = 0;
  int      requests_sent = 0;
  bit      calm = 1'b0;
  int      hold_order = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #100000;
    $display("FAILURE");
    $finish;
  end

  function automatic motion_t predict_motion(input logic [1:0] k, input logic [1:0] d,
                                             input logic [4:0] ups, input logic [4:0] downs);
    motion_t    r;
    logic [4:0] live;
    logic [1:0] hit;
    case (k)
      KIND_TICK: begin
        if (run_m) begin
          if (elapsed_m < timeout_m) begin
            for (int w = 0; w < WALL_SLOTS; w++) begin
              if (!done_m[w]) begin
                hit = DIR_NONE;
                if (downs[w] && latch_m[w] != DIR_DOWN) begin
                  latch_m[w] = DIR_DOWN;
                  wall_cnt[w] = wall_cnt[w] + COUNT_W'(1);
                  hit = DIR_DOWN;
                end else if (ups[w] && latch_m[w] != DIR_UP) begin
                  latch_m[w] = DIR_UP;
                  hit = DIR_UP;
                end
                if (hit != DIR_NONE && hit == dir_m) done_m[w] = 1'b1;
              end
            end
            elapsed_m = elapsed_m + TICK_W'(1);
          end
          if (elapsed_m >= timeout_m) begin
            run_m = 1'b0;
            tflag_m = (done_m != ALL_WALLS);
          end
        end
      end
      KIND_START: begin
        if (d == DIR_DOWN || d == DIR_UP) begin
          run_m = 1'b1;
          dir_m = d;
          elapsed_m = '0;
          done_m = '0;
          tflag_m = 1'b0;
        end
      end
      KIND_CLEAR: begin
        for (int w = 0; w < WALL_SLOTS; w++) wall_cnt[w] = '0;
      end
      default: ;
    endcase
    live = run_m ? (~done_m & ALL_WALLS) : 5'd0;
    r.down_mask = (dir_m == DIR_DOWN) ? live : 5'd0;
    r.up_mask = (dir_m == DIR_UP) ? live : 5'd0;
    r.down_lvl = (r.down_mask != 0) ? down_duty_m : '0;
    r.up_lvl = (r.up_mask != 0) ? up_duty_m : '0;
    r.busy = run_m;
    r.tout = tflag_m;
    for (int w = 0; w < WALL_SLOTS; w++) r.counts[w] = wall_cnt[w];
    return r;
  endfunction

  function automatic logic [4:0] switch_pattern();
    case ($urandom_range(0, 5))
      0: return 5'($urandom_range(0, 31));
      1: return 5'd0;
      default: return 5'($urandom & $urandom);
    endcase
  endfunction

  function automatic logic [DUTY_W-1:0] duty_pick();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return DUTY_RESET;
      default: return DUTY_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] want,
                                 input logic [COUNT_W-1:0] got);
    errors++;
    if (errors <= 20)
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
  endtask

  task automatic send_request(input logic [1:0] k, input logic [1:0] d,
                              input logic [4:0] ups, input logic [4:0] downs);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    run_direction <= d;
    up_switches <= ups;
    down_switches <= downs;
    do @(posedge clk); while (!in_ready);
    pending_motion.push_back(predict_motion(k, d, ups, downs));
    requests_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_UP_DUTY: up_duty_m = data[DUTY_W-1:0];
      CFG_DOWN_DUTY: down_duty_m = data[DUTY_W-1:0];
      CFG_TIMEOUT: timeout_m = data;
      default: ;
    endcase
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_request(KIND_CLEAR, 2'($urandom_range(0, 3)), switch_pattern(), switch_pattern());
      1: send_request(KIND_SPARE, 2'($urandom_range(0, 3)), switch_pattern(), switch_pattern());
      2: send_request(KIND_START, $urandom_range(0, 1) ? DIR_NONE : DIR_BAD,
                      switch_pattern(), switch_pattern());
      default: send_request(KIND_START, $urandom_range(0, 1) ? DIR_DOWN : DIR_UP,
                            switch_pattern(), switch_pattern());
    endcase
  endtask

  task automatic pick_settings();
    logic [TICK_W-1:0] t;
    case ($urandom_range(0, 19))
      0: t = '0;
      1: t = 16'hffff;
      default: t = TICK_W'($urandom_range(1, 24));
    endcase
    write_register(CFG_UP_DUTY, {8'($urandom), duty_pick()});
    write_register(CFG_DOWN_DUTY, {8'($urandom), duty_pick()});
    write_register(CFG_TIMEOUT, t);
  endtask

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin : result_sink
    int hold_seen;
    int hold_left;
    if (hold_seen != hold_order) begin
      hold_seen = hold_order;
      hold_left = HOLD_LEN;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin : check_results
    motion_t want;
    motion_t got;
    if (!rst && out_valid && out_ready) begin
      got.down_mask = drive_down_mask;
      got.up_mask = drive_up_mask;
      got.down_lvl = down_level;
      got.up_lvl = up_level;
      got.busy = busy_res;
      got.tout = timed_out;
      got.counts = {count_wall4, count_wall3, count_wall2, count_wall1, count_wall0};
      if (pending_motion.size() == 0) begin
        report_mismatch("result with no request", '0, '0);
      end else begin
        want = pending_motion.pop_front();
        if (got.down_mask !== want.down_mask)
          report_mismatch("drive_down_mask", COUNT_W'(want.down_mask),
                          COUNT_W'(got.down_mask));
        if (got.up_mask !== want.up_mask)
          report_mismatch("drive_up_mask", COUNT_W'(want.up_mask), COUNT_W'(got.up_mask));
        if (got.down_lvl !== want.down_lvl)
          report_mismatch("down_level", COUNT_W'(want.down_lvl), COUNT_W'(got.down_lvl));
        if (got.up_lvl !== want.up_lvl)
          report_mismatch("up_level", COUNT_W'(want.up_lvl), COUNT_W'(got.up_lvl));
        if (got.busy !== want.busy)
          report_mismatch("busy_res", COUNT_W'(want.busy), COUNT_W'(got.busy));
        if (got.tout !== want.tout)
          report_mismatch("timed_out", COUNT_W'(want.tout), COUNT_W'(got.tout));
        for (int w = 0; w < WALL_SLOTS; w++)
          if (got.counts[w] !== want.counts[w])
            report_mismatch($sformatf("count_wall%0d", w), want.counts[w], got.counts[w]);
      end
    end
  end

  // tick while idle, unknown kind, starts with no direction, clear while idle
  task automatic test_idle_commands();
    send_request(KIND_TICK, DIR_NONE, ALL_WALLS, ALL_WALLS);
    send_request(KIND_SPARE, DIR_DOWN, ALL_WALLS, ALL_WALLS);
    send_request(KIND_START, DIR_NONE, 5'd0, 5'd0);
    send_request(KIND_START, DIR_BAD, ALL_WALLS, 5'd0);
    send_request(KIND_CLEAR, DIR_UP, 5'd0, ALL_WALLS);
  endtask

  task automatic test_down_run();
    write_register(CFG_TIMEOUT, 16'd6);
    send_request(KIND_START, DIR_DOWN, 5'd0, 5'd0);
    send_request(KIND_TICK, DIR_NONE, 5'h1c, 5'h03);
    send_request(KIND_TICK, DIR_NONE, 5'd0, ALL_WALLS);
    send_request(KIND_TICK, DIR_NONE, ALL_WALLS, ALL_WALLS);
    repeat (3) send_request(KIND_TICK, DIR_NONE, 5'd0, 5'd0);
  endtask

  // both switches high favors down; restart mid-run flips the drives
  task automatic test_up_run_and_restart();
    write_register(CFG_UP_DUTY, 16'hff00);
    write_register(CFG_DOWN_DUTY, 16'h00ff);
    send_request(KIND_START, DIR_UP, 5'd0, 5'd0);
    send_request(KIND_TICK, DIR_NONE, ALL_WALLS, ALL_WALLS);
    send_request(KIND_TICK, DIR_NONE, 5'h15, 5'd0);
    send_request(KIND_START, DIR_DOWN, 5'd0, 5'd0);
    send_request(KIND_TICK, DIR_NONE, ALL_WALLS, 5'd0);
    send_request(KIND_CLEAR, DIR_NONE, 5'd0, 5'd0);
    repeat (5) send_request(KIND_TICK, DIR_NONE, 5'd0, 5'h0a);
  endtask

  task automatic test_zero_timeout();
    write_register(CFG_TIMEOUT, 16'd0);
    send_request(KIND_START, DIR_UP, 5'd0, 5'd0);
    send_request(KIND_TICK, DIR_NONE, ALL_WALLS, ALL_WALLS);
  endtask

  // shrinking the timeout below the elapsed count ends the run at the next tick
  task automatic test_timeout_rewrite();
    write_register(CFG_UP_DUTY, 16'h00ff);
    write_register(CFG_TIMEOUT, 16'hffff);
    send_request(KIND_START, DIR_DOWN, 5'd0, 5'd0);
    repeat (3) send_request(KIND_TICK, DIR_NONE, 5'd0, 5'h01);
    write_register(CFG_TIMEOUT, 16'd2);
    send_request(KIND_TICK, DIR_NONE, 5'd0, ALL_WALLS);
    send_request(KIND_TICK, DIR_NONE, 5'd0, ALL_WALLS);
  endtask

  task automatic test_random_runs();
    int         stop_at;
    int         ticks;
    int         mid;
    logic [1:0] d;
    stop_at = requests_sent + 620;
    while (requests_sent < stop_at) begin
      calm = (requests_sent >= stop_at - 450) && (requests_sent < stop_at - 300);
      if ($urandom_range(0, 2) == 0) pick_settings();
      if ($urandom_range(0, 99) < 85) begin
        d = $urandom_range(0, 1) ? DIR_DOWN : DIR_UP;
        send_request(KIND_START, d, switch_pattern(), switch_pattern());
        ticks = (timeout_m > 40) ? 40 : int'(timeout_m) + $urandom_range(0, 3);
        mid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ticks) : -1;
        for (int i = 0; i < ticks; i++) begin
          if (i == mid) write_register(CFG_TIMEOUT, TICK_W'($urandom_range(0, ticks)));
          if ($urandom_range(0, 99) < 6) send_noise();
          send_request(KIND_TICK, 2'($urandom_range(0, 3)), switch_pattern(), switch_pattern());
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end
    calm = 1'b0;
  endtask

  // receiver holds off while requests keep coming, so the core stalls its input
  task automatic test_backpressure();
    write_register(CFG_TIMEOUT, 16'd20);
    calm = 1'b1;
    hold_order++;
    send_request(KIND_START, DIR_DOWN, 5'd0, 5'd0);
    repeat (24) send_request(KIND_TICK, DIR_NONE, switch_pattern(), switch_pattern());
    calm = 1'b0;
  endtask

  initial begin
    for (int w = 0; w < WALL_SLOTS; w++) begin
      latch_m[w] = DIR_NONE;
      wall_cnt[w] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_down_run();
    test_up_run_and_restart();
    test_zero_timeout();
    test_timeout_rewrite();
    test_random_runs();
    test_backpressure();
    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
